/* hw/rtl/erv_pkg.sv */
// ----------------------------------------------------------------------------
// erv_pkg
// Shared widths, types and constant tables of the Euler vector rotation unit.
// ----------------------------------------------------------------------------
package erv_pkg;

  localparam int unsigned COORD_W   = 18;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned COEF_FRAC = COEF_W - 2;
  localparam int unsigned PROD_W    = COORD_W + COEF_W;
  localparam int unsigned DOT_W     = PROD_W + 2;
  localparam int unsigned RND_W     = DOT_W - COEF_FRAC;
  localparam int unsigned TERM_W    = COEF_W + 2;
  localparam int unsigned NUM_ANGLE = 3;
  localparam int unsigned NUM_COEF  = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // cordic datapath: scale 2^30, full turn 2^32
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned ZW           = 33;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned CORDIC_DROP  = 30 - COEF_FRAC;
  localparam logic signed [CORDIC_W-1:0] CORDIC_ONE   = CORDIC_W'(64'sd1073741824);
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = CORDIC_W'(64'sd652032874);

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef coef_t [NUM_COEF-1:0]      coef_mat_t;
  typedef angle_t [NUM_ANGLE-1:0]    angle_set_t;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_FIRST  = 2'd0,
    CFG_ANGLE_SECOND = 2'd1,
    CFG_ANGLE_THIRD  = 2'd2
  } cfg_idx_e;

  // matrix builder sequencer
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_TRIG,
    BS_MUL,
    BS_ACC
  } build_state_e;

  // operands of one matrix build step
  typedef enum logic [2:0] {
    OP_C1, OP_S1, OP_C2, OP_S2, OP_C3, OP_S3, OP_A, OP_B
  } op_e;

  typedef enum logic [1:0] {
    DST_NONE, DST_A, DST_B
  } dst_e;

  typedef struct packed {
    op_e        opa;
    op_e        opb;
    logic       neg;
    logic       first;
    logic       last;
    logic [3:0] kidx;
    dst_e       dst;
  } mstep_t;

  localparam int unsigned NUM_MSTEP = 14;
  localparam int unsigned MSTEP_W   = 4;

  // one rounded product per step, summed into a coefficient or kept as operand A or B
  function automatic mstep_t mstep(input logic [MSTEP_W-1:0] i);
    mstep_t m;
    m = '{OP_C1, OP_C2, 1'b0, 1'b1, 1'b0, 4'd0, DST_A};
    unique case (i)
      4'd0:  m = '{OP_C1, OP_C2, 1'b0, 1'b1, 1'b0, 4'd0, DST_A};
      4'd1:  m = '{OP_S1, OP_C2, 1'b0, 1'b1, 1'b0, 4'd0, DST_B};
      4'd2:  m = '{OP_A,  OP_C3, 1'b0, 1'b1, 1'b0, 4'd0, DST_NONE};
      4'd3:  m = '{OP_S1, OP_S3, 1'b1, 1'b0, 1'b1, 4'd0, DST_NONE};
      4'd4:  m = '{OP_B,  OP_C3, 1'b0, 1'b1, 1'b0, 4'd1, DST_NONE};
      4'd5:  m = '{OP_C1, OP_S3, 1'b0, 1'b0, 1'b1, 4'd1, DST_NONE};
      4'd6:  m = '{OP_S2, OP_C3, 1'b1, 1'b1, 1'b1, 4'd2, DST_NONE};
      4'd7:  m = '{OP_A,  OP_S3, 1'b1, 1'b1, 1'b0, 4'd3, DST_NONE};
      4'd8:  m = '{OP_S1, OP_C3, 1'b1, 1'b0, 1'b1, 4'd3, DST_NONE};
      4'd9:  m = '{OP_B,  OP_S3, 1'b1, 1'b1, 1'b0, 4'd4, DST_NONE};
      4'd10: m = '{OP_C1, OP_C3, 1'b0, 1'b0, 1'b1, 4'd4, DST_NONE};
      4'd11: m = '{OP_S2, OP_S3, 1'b0, 1'b1, 1'b1, 4'd5, DST_NONE};
      4'd12: m = '{OP_C1, OP_S2, 1'b0, 1'b1, 1'b1, 4'd6, DST_NONE};
      4'd13: m = '{OP_S1, OP_S2, 1'b0, 1'b1, 1'b1, 4'd7, DST_NONE};
      default: m = '{OP_C1, OP_C2, 1'b0, 1'b1, 1'b0, 4'd0, DST_NONE};
    endcase
    return m;
  endfunction

  // arctangent table, full turn = 2^32
  function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] i);
    logic [31:0] a;
    a = 32'h0;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/erv_if.sv */
// ----------------------------------------------------------------------------
// erv_in_if / erv_out_if
// Valid/ready channels carrying input vectors and rotated results.
// ----------------------------------------------------------------------------
interface erv_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [erv_pkg::COORD_W-1:0] x_in;
  logic signed [erv_pkg::COORD_W-1:0] y_in;
  logic signed [erv_pkg::COORD_W-1:0] z_in;

  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface erv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [erv_pkg::COORD_W-1:0] x_out;
  logic signed [erv_pkg::COORD_W-1:0] y_out;
  logic signed [erv_pkg::COORD_W-1:0] z_out;
  logic                              clipped;

  modport source (output valid, x_out, y_out, z_out, clipped, input ready);
  modport sink   (input valid, x_out, y_out, z_out, clipped, output ready);
endinterface

/* hw/rtl/erv_cordic.sv */
// ----------------------------------------------------------------------------
// erv_cordic
// Iterative rotation-mode cordic: cosine and sine of one binary angle.
// ----------------------------------------------------------------------------
module erv_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  erv_pkg::angle_t       angle_i,
  output logic                  done_o,
  output erv_pkg::coef_t        cos_o,
  output erv_pkg::coef_t        sin_o
);
  import erv_pkg::*;

  logic                       run_q, fin_q, done_q, zero_q;
  logic [STEP_W-1:0]          step_q;
  logic [1:0]                 quad_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, x_d, y_d, dx, dy;
  logic signed [ZW-1:0]       z_q, z_d, at;
  logic signed [CORDIC_W-1:0] cx, sx, cy, sy, cr, sr;
  coef_t                      cos_q, sin_q;

  // one micro-rotation per cycle
  always_comb begin
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = $signed({1'b0, cordic_atan(step_q)});
    if (!z_q[ZW-1]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - at;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + at;
    end
  end

  // quadrant mapping and rounding to the coefficient format
  always_comb begin
    cx = zero_q ? CORDIC_ONE : x_q;
    sx = zero_q ? '0 : y_q;
    unique case (quad_q)
      2'd0: begin cy = cx;  sy = sx;  end
      2'd1: begin cy = -sx; sy = cx;  end
      2'd2: begin cy = -cx; sy = -sx; end
      default: begin cy = sx; sy = -cx; end
    endcase
    cr = (cy + (CORDIC_W'(1) <<< (CORDIC_DROP - 1))) >>> CORDIC_DROP;
    sr = (sy + (CORDIC_W'(1) <<< (CORDIC_DROP - 1))) >>> CORDIC_DROP;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fin_q && !start_i;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= angle_i[ANGLE_W-1 -: 2];
      zero_q <= (angle_i[ANGLE_W-3:0] == '0);
      z_q    <= $signed(ZW'({angle_i[ANGLE_W-3:0], {(32 - ANGLE_W){1'b0}}}));
      x_q    <= CORDIC_START;
      y_q    <= '0;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (fin_q) begin
      cos_q <= cr[COEF_W-1:0];
      sin_q <= sr[COEF_W-1:0];
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
endmodule

/* hw/rtl/erv_matrix_build.sv */
// ----------------------------------------------------------------------------
// erv_matrix_build
// Sequencer that rebuilds the 3x3 rotation matrix from the three angles.
// ----------------------------------------------------------------------------
module erv_matrix_build (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   restart_i,
  input  erv_pkg::angle_set_t    angles_i,
  output logic                   busy_o,
  output erv_pkg::coef_mat_t     coefs_o
);
  import erv_pkg::*;

  build_state_e             state_q, state_d;
  logic [1:0]               ang_q, ang_d;
  logic [MSTEP_W-1:0]       step_q, step_d;
  logic                     kick_q, kick_d;
  logic                     cdone, trig_ok;
  coef_t                    ccos, csin;
  coef_t                    c_q [NUM_ANGLE];
  coef_t                    s_q [NUM_ANGLE];
  coef_t                    a_q, b_q, opa, opb;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [TERM_W-1:0] acc_q, term, sum;
  logic signed [PROD_W-1:0] prnd;
  coef_t                    clamped;
  coef_mat_t                coef_q;
  mstep_t                   ms;

  erv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kick_q),
    .angle_i (angles_i[ang_q]),
    .done_o  (cdone),
    .cos_o   (ccos),
    .sin_o   (csin)
  );

  // a done pulse in a start cycle belongs to an abandoned run
  assign trig_ok = cdone && !kick_q;

  function automatic coef_t pick(input op_e o, input coef_t c1, input coef_t s1,
                                 input coef_t c2, input coef_t s2, input coef_t c3,
                                 input coef_t s3, input coef_t a, input coef_t b);
    coef_t r;
    r = c1;
    unique case (o)
      OP_C1: r = c1;
      OP_S1: r = s1;
      OP_C2: r = c2;
      OP_S2: r = s2;
      OP_C3: r = c3;
      OP_S3: r = s3;
      OP_A:  r = a;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic coef_t clamp(input logic signed [TERM_W-1:0] v);
    coef_t r;
    if (v > TERM_W'(COEF_ONE)) r = COEF_ONE;
    else if (v < -TERM_W'(COEF_ONE)) r = -COEF_ONE;
    else r = v[COEF_W-1:0];
    return r;
  endfunction

  // operand selection and term rounding
  always_comb begin
    ms   = mstep(step_q);
    opa  = pick(ms.opa, c_q[0], s_q[0], c_q[1], s_q[1], c_q[2], s_q[2], a_q, b_q);
    opb  = pick(ms.opb, c_q[0], s_q[0], c_q[1], s_q[1], c_q[2], s_q[2], a_q, b_q);
    prnd = (prod_q + (PROD_W'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    term = ms.neg ? -prnd[TERM_W-1:0] : prnd[TERM_W-1:0];
    sum  = (ms.first ? '0 : acc_q) + term;
    clamped = clamp(sum);
  end

  // next state
  always_comb begin
    state_d = state_q;
    ang_d   = ang_q;
    step_d  = step_q;
    kick_d  = 1'b0;
    if (restart_i) begin
      state_d = BS_TRIG;
      ang_d   = '0;
      kick_d  = 1'b1;
    end else begin
      unique case (state_q)
        BS_IDLE: ;
        BS_TRIG: begin
          if (trig_ok) begin
            if (ang_q == 2'(NUM_ANGLE - 1)) begin
              state_d = BS_MUL;
              step_d  = '0;
            end else begin
              ang_d  = ang_q + 1'b1;
              kick_d = 1'b1;
            end
          end
        end
        BS_MUL: state_d = BS_ACC;
        BS_ACC: begin
          step_d = step_q + 1'b1;
          if (step_q == MSTEP_W'(NUM_MSTEP - 1)) state_d = BS_IDLE;
          else state_d = BS_MUL;
        end
        default: state_d = BS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      ang_q   <= '0;
      step_q  <= '0;
      kick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ang_q   <= ang_d;
      step_q  <= step_d;
      kick_q  <= kick_d;
    end
  end

  // coefficient store, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_q[k] <= (k % 4 == 0) ? COEF_ONE : '0;
      end
    end else if (!restart_i && state_q == BS_ACC) begin
      if (ms.last) coef_q[ms.kidx] <= clamped;
      if (step_q == MSTEP_W'(NUM_MSTEP - 1)) coef_q[NUM_COEF-1] <= clamp(TERM_W'(c_q[1]));
    end
  end

  // trig results, products and partial sums
  always_ff @(posedge clk_i) begin
    if (state_q == BS_TRIG && trig_ok) begin
      c_q[ang_q] <= ccos;
      s_q[ang_q] <= csin;
    end
    if (state_q == BS_MUL) prod_q <= PROD_W'(opa * opb);
    if (state_q == BS_ACC) begin
      acc_q <= sum;
      if (ms.dst == DST_A) a_q <= prnd[COEF_W-1:0];
      if (ms.dst == DST_B) b_q <= prnd[COEF_W-1:0];
    end
  end

  assign busy_o  = (state_q != BS_IDLE);
  assign coefs_o = coef_q;
endmodule

/* hw/rtl/erv_lane.sv */
// ----------------------------------------------------------------------------
// erv_lane
// One matrix row times the input vector: products, rounding, saturation.
// ----------------------------------------------------------------------------
module erv_lane (
  input  logic            clk_i,
  input  logic            en1_i,
  input  logic            en2_i,
  input  erv_pkg::coef_t  k0_i,
  input  erv_pkg::coef_t  k1_i,
  input  erv_pkg::coef_t  k2_i,
  input  erv_pkg::coord_t x_i,
  input  erv_pkg::coord_t y_i,
  input  erv_pkg::coord_t z_i,
  output erv_pkg::coord_t res_o,
  output logic            clip_o
);
  import erv_pkg::*;

  localparam logic signed [RND_W-1:0] HI = RND_W'((64'sd1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] LO = -RND_W'(64'sd1 <<< (COORD_W - 1));

  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q;
  logic signed [DOT_W-1:0]  dot;
  logic signed [RND_W-1:0]  rnd;
  coord_t                   res_q, res_d;
  logic                     clip_q, clip_d;

  // rounded dot product with clamp
  always_comb begin
    dot = DOT_W'(p0_q) + DOT_W'(p1_q) + DOT_W'(p2_q)
        + (DOT_W'(1) <<< (COEF_FRAC - 1));
    rnd = dot[DOT_W-1:COEF_FRAC];
    if (rnd > HI) begin
      res_d  = HI[COORD_W-1:0];
      clip_d = 1'b1;
    end else if (rnd < LO) begin
      res_d  = LO[COORD_W-1:0];
      clip_d = 1'b1;
    end else begin
      res_d  = rnd[COORD_W-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      p0_q <= PROD_W'(k0_i * x_i);
      p1_q <= PROD_W'(k1_i * y_i);
      p2_q <= PROD_W'(k2_i * z_i);
    end
    if (en2_i) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;
endmodule

/* hw/rtl/euler_rotate_vector3_unit.sv */
// ----------------------------------------------------------------------------
// euler_rotate_vector3_unit
// Rotates Q2.15 vectors by a z-y-z Euler matrix built from three angles.
// ----------------------------------------------------------------------------
// Takes one vector per cycle unless the output stalls or a matrix rebuild is
// running; each vector passes the lane product registers and then the result
// registers. Three row lanes multiply in parallel and the merge stage ORs
// their saturation flags into clipped. Writing an angle register rebuilds the
// matrix with one shared iterative cordic and a single multiplier (14
// products); during the rebuild the input channel is held not ready.
module euler_rotate_vector3_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  erv_in_if.sink                              in_i,
  erv_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [erv_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [erv_pkg::ANGLE_W-1:0]         cfg_data_i
);
  import erv_pkg::*;

  angle_set_t angle_q;
  logic       cfg_hit, busy;
  coef_mat_t  coefs;
  logic       v1_q, ov_q, en1, en2, take;
  logic       clip [3];
  coord_t     res  [3];

  // configuration writes
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_ANGLE_FIRST ||
                                cfg_idx_i == CFG_ANGLE_SECOND ||
                                cfg_idx_i == CFG_ANGLE_THIRD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (cfg_hit) begin
      angle_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  erv_matrix_build u_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_hit),
    .angles_i  (angle_q),
    .busy_o    (busy),
    .coefs_o   (coefs)
  );

  // pipeline flow control
  assign en2  = !ov_q || out_o.ready;
  assign en1  = !v1_q || en2;
  assign in_i.ready = en1 && !busy;
  assign take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1) v1_q <= take;
      if (en2) ov_q <= v1_q;
    end
  end

  // row lanes
  for (genvar r = 0; r < 3; r++) begin : g_lane
    erv_lane u_lane (
      .clk_i  (clk_i),
      .en1_i  (en1),
      .en2_i  (en2),
      .k0_i   (coefs[3*r]),
      .k1_i   (coefs[3*r+1]),
      .k2_i   (coefs[3*r+2]),
      .x_i    (in_i.x_in),
      .y_i    (in_i.y_in),
      .z_i    (in_i.z_in),
      .res_o  (res[r]),
      .clip_o (clip[r])
    );
  end

  // merge
  assign out_o.valid   = ov_q;
  assign out_o.x_out   = res[0];
  assign out_o.y_out   = res[1];
  assign out_o.z_out   = res[2];
  assign out_o.clipped = clip[0] | clip[1] | clip[2];
endmodule
